FILE: design/magnetometer_sample_filter_assert.svh
// Assertion macros for the magnetometer sample filter.
`ifndef MAGNETOMETER_SAMPLE_FILTER_ASSERT_SVH
`define MAGNETOMETER_SAMPLE_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/msf_pkg.sv
// Package: types, constants and helpers of the magnetometer sample filter.
package msf_pkg;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned FIELD_W  = 23;
  localparam int unsigned DIFF_W   = FIELD_W + 1;
  localparam int unsigned LIMIT_W  = 24;
  localparam int unsigned RMAX_W   = 4;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SQ_W     = 2 * LIMIT_W;
  localparam int unsigned AXES     = 3;
  localparam int unsigned IN_DATA_W  = AXES * RAW_W;
  localparam int unsigned OUT_DATA_W = ((AXES * FIELD_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LIMIT_W-1:0]  SPIKE_LIMIT_RST = 24'd6400;
  localparam logic [RMAX_W-1:0]   REJECT_MAX_RST  = 4'd2;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 16'd6554;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [RAW_W-1:0] raw_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIKE_LIMIT = 2'd0,
    CFG_REJECT_MAX  = 2'd1,
    CFG_SMOOTH_W    = 2'd2
  } cfg_idx_t;

  function automatic logic byte_bad(input logic [7:0] b);
    return (b == BYTE_ZERO) || (b == BYTE_ONES);
  endfunction

  // -(raw - 32768) * 125 == (32768 - raw) * (128 - 4 + 1)
  function automatic field_t convert_axis(input raw_t raw);
    logic signed [RAW_W:0] c;
    c = $signed({1'b0, 1'b1, {(RAW_W-1){1'b0}}}) - $signed({1'b0, raw});
    return FIELD_W'(({{(FIELD_W-RAW_W-1){c[RAW_W]}}, c} <<< 7)
                  - ({{(FIELD_W-RAW_W-1){c[RAW_W]}}, c} <<< 2)
                  +  {{(FIELD_W-RAW_W-1){c[RAW_W]}}, c});
  endfunction

  function automatic field_t mid3(input field_t a, input field_t b, input field_t c);
    field_t lo;
    field_t hi;
    field_t m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

FILE: design/magnetometer_sample_filter.sv
// An accepted burst passes through stage 1 and stage 2 to the output register.
// Throughput: one burst per cycle; the stages hold only while the output stalls.
// Stage 1 registers the burst, stage 2 holds the median; sm_r loops back. The output
// register holds the median while calibrating or before sm_r is first set, else the
// spike-checked, smoothed field. Reset (rst_n low, synchronous) empties the pipe,
// clears history, smoothing and reject count and loads the default configuration.
// Magnetometer sample filter top level: byte check, median, spike reject, smoothing.
`include "magnetometer_sample_filter_assert.svh"

module magnetometer_sample_filter import msf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_raw, y_raw, z_raw
  input  logic                  in_tuser,   // calibrating
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // x_field, y_field, z_field, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  logic [LIMIT_W-1:0]  spike_limit_r;
  logic [RMAX_W-1:0]   reject_max_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [SQ_W-1:0]     lim2_r;

  logic                 v1_r;
  logic [IN_DATA_W-1:0] raw1_r;
  logic                 cal1_r;

  logic    v2_r;
  logic    cal2_r;
  field_t  f2_r [AXES];

  field_t  hist0_r [AXES];
  field_t  hist1_r [AXES];
  logic [1:0] hist_cnt_r;

  field_t  sm_r [AXES];
  logic    have_sm_r;
  logic [RMAX_W-1:0] rc_r;
  logic [RMAX_W-1:0] rc_nxt;

  logic    out_valid_r;
  field_t  out_r [AXES];

  logic    en_out;
  logic    en2;
  logic    en1;
  logic    bad1;
  field_t  cur1 [AXES];
  field_t  med1 [AXES];

  logic signed [DIFF_W-1:0]          d2 [AXES];
  logic [SQ_W-1:0]                   sq2 [AXES];
  logic signed [DIFF_W+WEIGHT_W:0]   wd2 [AXES];
  logic signed [DIFF_W+1:0]          step2 [AXES];
  field_t                            bl2 [AXES];
  logic [SQ_W-1:0]                   dist2;
  logic                              spike;
  logic                              drop2;
  logic                              fire2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_limit_r <= SPIKE_LIMIT_RST;
      reject_max_r  <= REJECT_MAX_RST;
      weight_r      <= WEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPIKE_LIMIT: spike_limit_r <= cfg_data;
        CFG_REJECT_MAX:  reject_max_r  <= cfg_data[RMAX_W-1:0];
        CFG_SMOOTH_W:    weight_r      <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim2_r <= spike_limit_r * spike_limit_r;
  end

  assign en_out    = !out_valid_r || out_tready;
  assign en2       = !v2_r || en_out;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      raw1_r <= in_tdata;
      cal1_r <= in_tuser;
    end
  end

  always_comb begin
    bad1 = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      bad1 = bad1 || byte_bad(raw1_r[i*RAW_W+8 +: 8]) || byte_bad(raw1_r[i*RAW_W +: 8]);
      cur1[i] = convert_axis(raw1_r[i*RAW_W +: RAW_W]);
      med1[i] = (hist_cnt_r == 2'd2) ? mid3(hist0_r[i], hist1_r[i], cur1[i]) : cur1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      hist_cnt_r <= 2'd0;
    end else if (en2) begin
      v2_r <= v1_r && !bad1;
      if (v1_r && !bad1 && hist_cnt_r != 2'd2) begin
        hist_cnt_r <= hist_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r && !bad1) begin
      cal2_r <= cal1_r;
      for (int i = 0; i < AXES; i++) begin
        f2_r[i] <= med1[i];
        case (hist_cnt_r)
          2'd0: hist0_r[i] <= cur1[i];
          2'd1: hist1_r[i] <= cur1[i];
          default: begin
            hist0_r[i] <= hist1_r[i];
            hist1_r[i] <= cur1[i];
          end
        endcase
      end
    end
  end

  // smoothing: s + floor((d*w + 2^15) / 2^16), d = f - s
  always_comb begin
    dist2 = '0;
    for (int i = 0; i < AXES; i++) begin
      d2[i]    = DIFF_W'(f2_r[i]) - DIFF_W'(sm_r[i]);
      sq2[i]   = d2[i] * d2[i];
      wd2[i]   = d2[i] * $signed({1'b0, weight_r});
      step2[i] = (DIFF_W+2)'((wd2[i] + (DIFF_W+WEIGHT_W+1)'(32768)) >>> WEIGHT_W);
      bl2[i]   = FIELD_W'((DIFF_W+2)'(sm_r[i]) + step2[i]);
      dist2    = dist2 + sq2[i];
    end
    spike = dist2 > lim2_r;
  end

  assign fire2 = v2_r && en_out;
  assign drop2 = !cal2_r && have_sm_r && spike && (rc_r < reject_max_r);

  always_comb begin
    rc_nxt = rc_r;
    if (fire2 && !cal2_r && have_sm_r) begin
      rc_nxt = drop2 ? rc_r + RMAX_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= '0;
      have_sm_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rc_r <= rc_nxt;
      if (fire2 && !cal2_r) begin
        have_sm_r <= 1'b1;
      end
      if (en_out) begin
        out_valid_r <= v2_r && !drop2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && !drop2) begin
      for (int i = 0; i < AXES; i++) begin
        if (cal2_r || !have_sm_r) begin
          out_r[i] <= f2_r[i];
        end else begin
          out_r[i] <= bl2[i];
        end
        if (!cal2_r) begin
          sm_r[i] <= have_sm_r ? bl2[i] : f2_r[i];
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-AXES*FIELD_W){1'b0}}, out_r[2], out_r[1], out_r[0]};

  `MSF_ASSERT_NEXT(a_in_to_stage1, in_tvalid && in_tready, v1_r,
    "accepted burst did not reach stage 1")
  `MSF_ASSERT_NEXT(a_have_sm_sticky, have_sm_r, have_sm_r,
    "smoothed-field flag cleared outside reset")
  `MSF_ASSERT_NOW(a_rc_inc_on_drop, rc_nxt != rc_r && rc_nxt != '0,
    fire2 && !cal2_r && spike,
    "reject count advanced without a dropped spike")
  `MSF_ASSERT_NEXT(a_no_phantom_out, !out_valid_r && !v2_r, !out_valid_r,
    "result appeared with no item in stage 2")
  `MSF_ASSERT_NOW(a_hist_cnt_sat, v2_r && hist_cnt_r == 2'd0, 1'b0,
    "stage 2 holds a sample that never entered the history")

endmodule

FILE: verif/tb.sv
// Testbench for magnetometer_sample_filter: a filter predictor checks every transfer under random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msf_pkg::*;

  typedef logic [AXES-1:0][FIELD_W-1:0] axes_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 325;
  localparam int PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class field_scoreboard;
    logic [LIMIT_W-1:0]  limit;
    logic [RMAX_W-1:0]   reject_max;
    logic [WEIGHT_W-1:0] weight;
    field_t              hist[2*AXES];
    int unsigned         hist_n;
    field_t              smooth[AXES];
    bit                  have_smooth;
    logic [RMAX_W-1:0]   reject_n;
    axes_t               expected_q[$];
    int unsigned         errors;

    function new();
      limit = SPIKE_LIMIT_RST;
      reject_max = REJECT_MAX_RST;
      weight = WEIGHT_RST;
      hist_n = 0;
      have_smooth = 1'b0;
      reject_n = '0;
      errors = 0;
      foreach (hist[i]) hist[i] = '0;
      foreach (smooth[i]) smooth[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      case (idx)
        CFG_SPIKE_LIMIT: limit = val;
        CFG_REJECT_MAX:  reject_max = val[RMAX_W-1:0];
        CFG_SMOOTH_W:    weight = val[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit byte_is_rail(logic [7:0] b);
      return (b == BYTE_ZERO) || (b == BYTE_ONES);
    endfunction

    function field_t median3(field_t a, field_t b, field_t c);
      int sa;
      int sb;
      int sc;
      int hi;
      int lo;
      sa = a;
      sb = b;
      sc = c;
      hi = (sa > sb) ? sa : sb;
      hi = (hi > sc) ? hi : sc;
      lo = (sa < sb) ? sa : sb;
      lo = (lo < sc) ? lo : sc;
      return field_t'(sa + sb + sc - hi - lo);
    endfunction

    function field_t blend(field_t s, field_t f);
      longint acc;
      acc = longint'(s) * (65536 - longint'(weight)) + longint'(f) * longint'(weight);
      return field_t'((acc + 32768) >>> 16);
    endfunction

    function void note_burst(logic [IN_DATA_W-1:0] data, bit calib);
      raw_t   r;
      field_t cur[AXES];
      field_t med[AXES];
      axes_t  res;
      longint dist2;
      longint d;
      longint lim2;
      for (int a = 0; a < AXES; a++) begin
        r = data[a*RAW_W +: RAW_W];
        if (byte_is_rail(r[15:8]) || byte_is_rail(r[7:0])) return;
        cur[a] = field_t'((32768 - int'(r)) * 125);
      end
      for (int a = 0; a < AXES; a++)
        med[a] = (hist_n >= 2) ? median3(hist[a], hist[AXES+a], cur[a]) : cur[a];
      if (hist_n < 2) begin
        for (int a = 0; a < AXES; a++) hist[hist_n*AXES + a] = cur[a];
        hist_n++;
      end else begin
        for (int a = 0; a < AXES; a++) begin
          hist[a] = hist[AXES+a];
          hist[AXES+a] = cur[a];
        end
      end
      if (!calib) begin
        if (have_smooth) begin
          dist2 = 0;
          lim2 = longint'(limit) * longint'(limit);
          for (int a = 0; a < AXES; a++) begin
            d = longint'(med[a]) - longint'(smooth[a]);
            dist2 += d * d;
          end
          if (dist2 > lim2 && reject_n < reject_max) begin
            reject_n++;
            return;
          end
          reject_n = '0;
          for (int a = 0; a < AXES; a++) med[a] = blend(smooth[a], med[a]);
        end else begin
          have_smooth = 1'b1;
        end
        for (int a = 0; a < AXES; a++) smooth[a] = med[a];
      end
      for (int a = 0; a < AXES; a++) res[a] = med[a];
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    task check(axes_t got);
      axes_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      for (int a = 0; a < AXES; a++)
        if (got[a] !== want[a])
          report($sformatf("axis %0d field: got %0d, want %0d", a,
                           $signed(got[a]), $signed(want[a])));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // x_raw, y_raw, z_raw
  logic                  in_tuser = 1'b0; // calibrating
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // x_field, y_field, z_field, zero pad
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LIMIT_W-1:0]    cfg_data = '0;

  field_scoreboard sb;
  int  stall_cycles = 0;
  int  ready_wait = 0;
  bit  in_idle_on = 1'b1;
  bit  out_stall_on = 1'b1;
  int  walk_base[AXES];

  magnetometer_sample_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (ready_wait != 0) begin
      out_tready <= 1'b0;
      ready_wait <= ready_wait - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_stall_on && $urandom_range(0, 4) == 0) ready_wait <= pick_gap();
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check(axes_t'(out_tdata[AXES*FIELD_W-1:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_burst(raw_t x, raw_t y, raw_t z, bit calib);
    int gap;
    gap = (in_idle_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    in_tuser <= calib;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_burst({z, y, x}, calib);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic raw_t legal_raw(int v);
    raw_t r;
    if (v < 257) v = 257;
    if (v > 65278) v = 65278;
    r = raw_t'(v);
    if (r[7:0] == BYTE_ZERO) r[7:0] = 8'h01;
    if (r[7:0] == BYTE_ONES) r[7:0] = 8'hFE;
    return r;
  endfunction

  task automatic random_burst();
    raw_t r[AXES];
    int   kind;
    int   amp;
    int   axis;
    bit   calib;
    kind = $urandom_range(0, 99);
    calib = ($urandom_range(0, 99) < 8);
    case ($urandom_range(0, 2))
      0: amp = 3;
      1: amp = 40;
      default: amp = 600;
    endcase
    if (kind >= 12 && kind < 15)
      for (int a = 0; a < AXES; a++) walk_base[a] = $urandom_range(257, 65278);
    for (int a = 0; a < AXES; a++) begin
      if (kind < 12) begin
        r[a] = legal_raw($urandom_range(0, 65535));
      end else begin
        walk_base[a] = legal_raw(walk_base[a] + int'($urandom_range(0, 40)) - 20);
        r[a] = legal_raw(walk_base[a] + int'($urandom_range(0, 2 * amp)) - amp);
      end
    end
    // corrupt one byte: burst must be dropped
    if (kind < 5) begin
      axis = $urandom_range(0, AXES - 1);
      r[axis][8*$urandom_range(0, 1) +: 8] = ($urandom_range(0, 1) == 1) ? BYTE_ONES : BYTE_ZERO;
    end
    send_burst(r[0], r[1], r[2], calib);
  endtask

  initial begin
    logic [LIMIT_W-1:0]  ph_limit[PHASES];
    logic [RMAX_W-1:0]   ph_rmax[PHASES];
    logic [WEIGHT_W-1:0] ph_weight[PHASES];
    ph_limit  = '{24'd6400, 24'd0, 24'hFFFFFF, 24'd200, 24'd3000, 24'($urandom)};
    ph_rmax   = '{4'd2, 4'd0, 4'd15, 4'd15, 4'd1, 4'($urandom)};
    ph_weight = '{16'd6554, 16'hFFFF, 16'd0, 16'd1, 16'd32768, 16'($urandom)};
    sb = new();
    for (int a = 0; a < AXES; a++) walk_base[a] = $urandom_range(257, 65278);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // dropped bursts: rail bytes in high and low positions
    send_burst(16'h0080, 16'h8181, 16'h8181, 1'b0);
    send_burst(16'h8181, 16'h80FF, 16'h8181, 1'b0);
    send_burst(16'h8181, 16'h8181, 16'hFF80, 1'b1);
    send_burst(16'h8000, 16'hFFFF, 16'h0000, 1'b0);
    // short history while calibrating, then first smoothed value
    send_burst(16'h0101, 16'hFEFE, 16'h8080, 1'b1);
    send_burst(16'hFEFE, 16'h0101, 16'h7F7F, 1'b0);
    // large step: spikes dropped until the reject count runs out
    send_burst(16'h8181, 16'h8181, 16'h8181, 1'b0);
    send_burst(16'h8181, 16'h8181, 16'h8181, 1'b0);
    send_burst(16'h8181, 16'h8181, 16'h8181, 1'b0);
    send_burst(16'h8181, 16'h8181, 16'h8181, 1'b0);
    send_burst(16'h8182, 16'h8183, 16'h8180, 1'b0);
    send_burst(16'h2020, 16'hE0E0, 16'h2020, 1'b1);
    send_burst(16'h8184, 16'h8185, 16'h817E, 1'b0);
    send_burst(16'h55AA, 16'hAA55, 16'h5A5A, 1'b0);
    send_burst(16'h8186, 16'h8181, 16'h8182, 1'b0);
    send_burst(16'h8181, 16'h8182, 16'h8183, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_SPIKE_LIMIT, ph_limit[p]);
      write_reg(CFG_REJECT_MAX, {20'($urandom), ph_rmax[p]});
      write_reg(CFG_SMOOTH_W, {8'($urandom), ph_weight[p]});
      write_reg(CFG_UNUSED, 24'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          in_idle_on = ($urandom_range(0, 3) != 0);
          out_stall_on = ($urandom_range(0, 3) != 0);
        end
        random_burst();
      end
    end

    wait_idle();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/msf_pkg.sv
design/magnetometer_sample_filter.sv
verif/tb.sv
